// ===== sv/ackcw_pkg.sv =====
package ackcw_pkg;

    localparam int SEQ_WIDTH_DEF   = 15;
    localparam int QUEUE_DEPTH     = 2;
    localparam int IN_TDATA_W      = 24;
    localparam int IN_TUSER_W      = 2;
    localparam int OUT_TDATA_W     = 40;
    localparam int OUT_TUSER_W     = 3;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 8;

    // Reset values of the configuration registers.
    localparam logic [7:0] INIT_THRESH_RST = 8'd127;
    localparam logic [3:0] DUP_LIMIT_RST   = 4'd3;
    localparam logic [7:0] FLOOR_RST       = 8'd2;

    // Special ACK codes, as 16-bit two's complement.
    localparam logic [15:0] ACK_PROBE = 16'hFFFE;  // -2
    localparam logic [15:0] ACK_FIN   = 16'hFFF7;  // -9
    localparam logic [15:0] ACK_CLOSE = 16'hFFF6;  // -10

    typedef enum logic [1:0] {
        CFG_INIT_THRESH = 2'd0,
        CFG_DUP_LIMIT   = 2'd1,
        CFG_FLOOR       = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        FUNC_SENT    = 2'd0,
        FUNC_ACK     = 2'd1,
        FUNC_TIMEOUT = 2'd2,
        FUNC_FIN     = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        EV_SENT,
        EV_TIMEOUT,
        EV_FIN,
        EV_PROBE_OPEN,
        EV_FIN_ACK,
        EV_CLOSE,
        EV_SEQ_ACK,
        EV_OTHER_ACK
    } ev_op_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_PROBE   = 3'd2,
        KIND_FIN     = 3'd3,
        KIND_CLOSING = 3'd4
    } kind_t;

    typedef struct packed {
        ev_op_t      op;
        logic        is_ack;
        logic [15:0] ack_raw;
        logic [7:0]  adv;
    } entry_t;

    typedef struct packed {
        logic [7:0]  cong_window;
        logic [7:0]  slow_threshold;
        logic [7:0]  send_allowance;
        kind_t       resend_kind;
        logic [14:0] resend_seq;
        logic        peer_closed;
    } result_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

endpackage

// ===== sv/ack_congestion_window_control_core.sv =====
// Sender-side congestion window controller in the Reno style. Each input beat is
// one event (tuser selects segment sent, ACK, timeout or FIN sent; tdata carries
// the ACK number or code and the advertised window), and each event yields exactly
// one output beat with cwnd, ssthresh, the send allowance and any retransmit
// request. A decoder feeds a two-entry queue, and the state update drains it at
// one beat per clock unless the output stalls, so the block sustains one event per
// cycle; each event is queued and its result registered as it leaves the queue. The
// window update sets that rate. Configuration writes must be issued only while
// no event is in flight; writing the initial threshold reloads ssthresh at once.
module ack_congestion_window_control_core #(
    parameter int SEQ_WIDTH = ackcw_pkg::SEQ_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // ack_code[15:0], adv_window[23:16]
    input  logic [ackcw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [ackcw_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // cong_window[7:0], slow_threshold[15:8], send_allowance[23:16],
    // resend_seq[38:24], peer_closed[39]
    output logic [ackcw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // resend_kind[2:0]
    output logic [ackcw_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ackcw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ackcw_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ackcw_pkg::*;

    entry_t  push_entry;
    entry_t  head;
    logic    push;
    logic    pop;
    logic    queue_full;
    logic    queue_empty;
    cfg_wr_t cfg_wr;
    result_t result;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    ackcw_front u_front (
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .func       (func_t'(s_axis_tuser)),
        .ack_code   (s_axis_tdata[15:0]),
        .adv_window (s_axis_tdata[23:16]),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    ackcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    ackcw_back #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_wr),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (result)
    );

    assign m_axis_tdata = {result.peer_closed, result.resend_seq, result.send_allowance,
                           result.slow_threshold, result.cong_window};
    assign m_axis_tuser = result.resend_kind;

endmodule

// ===== sv/ackcw_front.sv =====
module ackcw_front (
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ackcw_pkg::func_t      func,
    input  logic signed [15:0]    ack_code,
    input  logic [7:0]            adv_window,
    input  logic                  queue_full,
    output logic                  push,
    output ackcw_pkg::entry_t     entry
);
    import ackcw_pkg::*;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        entry.ack_raw = ack_code;
        entry.adv     = adv_window;
        entry.is_ack  = (func == FUNC_ACK);
        entry.op      = EV_OTHER_ACK;
        unique case (func)
            FUNC_SENT:    entry.op = EV_SENT;
            FUNC_TIMEOUT: entry.op = EV_TIMEOUT;
            FUNC_FIN:     entry.op = EV_FIN;
            FUNC_ACK:
            begin
                // A probe reply with a closed window is handled like a timeout.
                if (ack_code == ACK_PROBE)
                    entry.op = (adv_window != 8'd0) ? EV_PROBE_OPEN : EV_TIMEOUT;
                else if (ack_code == ACK_FIN)
                    entry.op = EV_FIN_ACK;
                else if (ack_code == ACK_CLOSE)
                    entry.op = EV_CLOSE;
                else if (!ack_code[15])
                    entry.op = EV_SEQ_ACK;
                else
                    entry.op = EV_OTHER_ACK;
            end
        endcase
    end

endmodule

// ===== sv/ackcw_queue.sv =====
module ackcw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ackcw_pkg::entry_t push_entry,
    input  logic              pop,
    output ackcw_pkg::entry_t head,
    output logic              full,
    output logic              empty
);
    import ackcw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== sv/ackcw_back.sv =====
module ackcw_back #(
    parameter int SEQ_WIDTH = ackcw_pkg::SEQ_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ackcw_pkg::cfg_wr_t cfg_wr,
    input  ackcw_pkg::entry_t  head,
    input  logic               queue_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output ackcw_pkg::result_t out_result
);
    import ackcw_pkg::*;

    localparam int CMP_W = (SEQ_WIDTH > 15) ? SEQ_WIDTH : 15;

    logic [3:0]           dup_limit_reg;
    logic [7:0]           floor_reg;

    logic [7:0]           cwnd_reg, cwnd_next;
    logic [7:0]           ssthresh_reg, ssthresh_next;
    logic                 slow_start_reg, slow_start_next;
    logic [7:0]           fraction_reg, fraction_next;
    logic [SEQ_WIDTH-1:0] oldest_reg, oldest_next;
    logic [SEQ_WIDTH-1:0] next_seq_reg, next_seq_next;
    logic [7:0]           peer_win_reg, peer_win_next;
    logic [15:0]          last_ack_reg, last_ack_next;
    logic [3:0]           dup_count_reg, dup_count_next;
    logic                 fin_sent_reg, fin_sent_next;
    logic                 fin_acked_reg, fin_acked_next;

    logic                 out_valid_reg;
    result_t              result_reg, result_next;

    logic [CMP_W-1:0]     ack_cmp;
    logic [CMP_W-1:0]     oldest_cmp;
    logic [SEQ_WIDTH-1:0] ack_masked;
    logic [7:0]           cwnd_inc;
    logic [8:0]           fraction_inc;
    logic [SEQ_WIDTH-1:0] outstanding;
    logic [SEQ_WIDTH-1:0] cwnd_wide;
    logic [7:0]           space;
    kind_t                kind;
    logic [14:0]          resend_seq;
    logic                 closed;

    // Threshold after a loss: half the usable window, not below the floor.
    function automatic logic [7:0] loss_thresh(input logic [7:0] cw, input logic [7:0] pw,
                                               input logic [7:0] fl);
        logic [7:0] m;
        m = (cw < pw) ? cw : pw;
        m = m >> 1;
        return (m > fl) ? m : fl;
    endfunction

    assign pop        = !queue_empty && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    assign ack_cmp    = CMP_W'(head.ack_raw[14:0]);
    assign oldest_cmp = CMP_W'(oldest_reg);
    assign ack_masked = SEQ_WIDTH'(ack_cmp);
    assign cwnd_inc   = (cwnd_reg == 8'hFF) ? cwnd_reg : cwnd_reg + 8'd1;
    assign fraction_inc = {1'b0, fraction_reg} + 9'd1;

    always_comb
    begin
        cwnd_next       = cwnd_reg;
        ssthresh_next   = ssthresh_reg;
        slow_start_next = slow_start_reg;
        fraction_next   = fraction_reg;
        oldest_next     = oldest_reg;
        next_seq_next   = next_seq_reg;
        peer_win_next   = peer_win_reg;
        last_ack_next   = last_ack_reg;
        dup_count_next  = dup_count_reg;
        fin_sent_next   = fin_sent_reg;
        fin_acked_next  = fin_acked_reg;
        kind            = KIND_NONE;
        resend_seq      = '0;
        closed          = 1'b0;

        if (pop)
        begin
            unique case (head.op)
                EV_SENT:
                    next_seq_next = next_seq_reg + 1'b1;
                EV_TIMEOUT:
                begin
                    if (peer_win_reg != 8'd0 && !fin_sent_reg)
                        kind = KIND_DATA;
                    else if (peer_win_reg == 8'd0)
                        kind = KIND_PROBE;
                    if (fin_sent_reg && !fin_acked_reg)
                        kind = KIND_FIN;
                    if (fin_acked_reg)
                        kind = KIND_CLOSING;
                    if (kind == KIND_DATA)
                        resend_seq = 15'(oldest_cmp);
                    ssthresh_next   = loss_thresh(cwnd_reg, peer_win_reg, floor_reg);
                    cwnd_next       = 8'd1;
                    fraction_next   = 8'd0;
                    slow_start_next = 1'b1;
                end
                EV_FIN:
                    fin_sent_next = 1'b1;
                EV_PROBE_OPEN:
                    peer_win_next = head.adv;
                EV_FIN_ACK:
                    fin_acked_next = 1'b1;
                EV_CLOSE:
                    closed = 1'b1;
                EV_SEQ_ACK:
                begin
                    if (ack_cmp > oldest_cmp)
                    begin
                        oldest_next   = ack_masked;
                        peer_win_next = head.adv;
                        if (cwnd_reg >= ssthresh_reg)
                        begin
                            // Congestion avoidance: one segment per window of ACKs.
                            slow_start_next = 1'b0;
                            if (fraction_inc >= {1'b0, cwnd_reg})
                            begin
                                fraction_next = 8'd0;
                                cwnd_next     = cwnd_inc;
                            end
                            else
                            begin
                                fraction_next = fraction_inc[7:0];
                            end
                        end
                        else if (slow_start_reg)
                        begin
                            cwnd_next = cwnd_inc;
                        end
                    end
                end
                EV_OTHER_ACK:
                begin
                end
            endcase

            if (head.is_ack)
            begin
                if (last_ack_reg != head.ack_raw)
                begin
                    dup_count_next = 4'd0;
                    last_ack_next  = head.ack_raw;
                end
                else if (dup_count_reg != 4'hF)
                begin
                    dup_count_next = dup_count_reg + 4'd1;
                end
                // Fast retransmit works on the window as this ACK left it.
                if (dup_count_next >= dup_limit_reg)
                begin
                    dup_count_next = 4'd0;
                    if (!head.ack_raw[15])
                    begin
                        ssthresh_next = loss_thresh(cwnd_next, peer_win_next, floor_reg);
                        kind          = KIND_DATA;
                        resend_seq    = 15'(CMP_W'(ack_masked));
                    end
                end
            end
        end

        outstanding = next_seq_next - oldest_next;
        cwnd_wide   = SEQ_WIDTH'(cwnd_next);
        space       = (cwnd_wide > outstanding) ? 8'(cwnd_wide - outstanding) : 8'd0;

        result_next.cong_window    = cwnd_next;
        result_next.slow_threshold = ssthresh_next;
        result_next.send_allowance = (space < peer_win_next) ? space : peer_win_next;
        result_next.resend_kind    = kind;
        result_next.resend_seq     = resend_seq;
        result_next.peer_closed    = closed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dup_limit_reg   <= DUP_LIMIT_RST;
            floor_reg       <= FLOOR_RST;
            cwnd_reg        <= 8'd1;
            ssthresh_reg    <= INIT_THRESH_RST;
            slow_start_reg  <= 1'b1;
            fraction_reg    <= '0;
            oldest_reg      <= '0;
            next_seq_reg    <= '0;
            peer_win_reg    <= '0;
            last_ack_reg    <= '0;
            dup_count_reg   <= '0;
            fin_sent_reg    <= 1'b0;
            fin_acked_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cwnd_reg       <= cwnd_next;
            slow_start_reg <= slow_start_next;
            fraction_reg   <= fraction_next;
            oldest_reg     <= oldest_next;
            next_seq_reg   <= next_seq_next;
            peer_win_reg   <= peer_win_next;
            last_ack_reg   <= last_ack_next;
            dup_count_reg  <= dup_count_next;
            fin_sent_reg   <= fin_sent_next;
            fin_acked_reg  <= fin_acked_next;
            // Writing the initial threshold also reloads ssthresh.
            if (cfg_wr.valid && cfg_index_t'(cfg_wr.index) == CFG_INIT_THRESH)
                ssthresh_reg <= cfg_wr.data;
            else
                ssthresh_reg <= ssthresh_next;
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_wr.valid)
            begin
                unique case (cfg_index_t'(cfg_wr.index))
                    CFG_INIT_THRESH:
                    begin
                    end
                    CFG_DUP_LIMIT:
                        dup_limit_reg <= cfg_wr.data[3:0];
                    CFG_FLOOR:
                        floor_reg <= cfg_wr.data;
                    CFG_UNUSED:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= result_next;
    end

endmodule

// ===== sv/ackcw_checker.sv =====
module ackcw_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ackcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [ackcw_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import ackcw_pkg::*;

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // The congestion window never drops below one segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] != 8'd0)
        else $error("cong_window is zero");

    // The send allowance never exceeds the congestion window.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:16] <= m_axis_tdata[7:0])
        else $error("send_allowance above cong_window");

    // Only a data retransmit carries a sequence number.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[38:24] == 15'd0)
        else $error("resend_seq set without a data retransmit");

    // Closing the connection is reported with no retransmit request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[39] |-> m_axis_tuser == KIND_NONE)
        else $error("peer_closed with a retransmit request");

endmodule

bind ack_congestion_window_control_core ackcw_checker u_ackcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
